/* src/sst_pkg.sv */
// package for the sorted stack count table
// shared constants, command and status codes; no dependencies
`default_nettype none

package sst_pkg;

   localparam int CAPACITY_DEFAULT = 16;
   localparam int KEY_BITS_DEFAULT = 16;

   localparam int COUNT_W = 16;
   localparam int TOTAL_W = 20;
   localparam int KEY_PORT_W = 16;

   localparam logic [COUNT_W-1:0] LIMIT_RESET = 16'd64;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_NOSPACE = 1'b1;

endpackage

`default_nettype wire

/* src/sst_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module sst_ram #(
   parameter int WIDTH     = 32,
   parameter int DEPTH     = 16,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

/* src/sorted_stack_count_table.sv */
// sorted stack count table: top level, sequencer over one slot ram
// depends on sst_pkg and sst_ram
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/ready    | cmd, item_key, add_count
//   rsp     | out       | rsp_valid/ready    | status, found, item_count, total_units
//   csr     | in        | csr_wr_en          | csr_wr_data (stack limit)
//
// a request scans the slots in order, each a ram read then a key compare;
// an insert of a new key then shifts each higher slot up and writes the entry
// the single ram read port sets this order; one request at a time
// reset clears state, count and total and sets the limit to LIMIT_RESET; ram contents are not cleared
// a stalled response holds the sequencer in its done state, req_ready stays low
`default_nettype none

module sorted_stack_count_table
   import sst_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT,
   parameter int KEY_BITS = KEY_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_cmd,
   input  wire logic [KEY_PORT_W-1:0] req_item_key,
   input  wire logic [COUNT_W-1:0]    req_add_count,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_status,
   output logic                       rsp_found,
   output logic [COUNT_W-1:0]         rsp_item_count,
   output logic [TOTAL_W-1:0]         rsp_total_units,
   input  wire logic                  csr_wr_en,
   input  wire logic [COUNT_W-1:0]    csr_wr_data
);

   localparam int IDX_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_BITS = $clog2(CAPACITY + 1);
   localparam int ENT_W    = KEY_BITS + COUNT_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD,
      S_CMP,
      S_DECIDE,
      S_SHR,
      S_SHW,
      S_INS,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   logic [CNT_BITS-1:0] idx_ff, idx_in;
   logic [CNT_BITS-1:0] pos_ff, pos_in;
   logic [CNT_BITS-1:0] used_ff, used_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [COUNT_W-1:0]  limit_ff;
   logic                cmd_ff, cmd_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [COUNT_W-1:0]  add_ff, add_in;
   logic                hit_ff, hit_in;
   logic [COUNT_W-1:0]  cnt_ff, cnt_in;
   logic                res_status_ff, res_status_in;
   logic                res_found_ff, res_found_in;
   logic [COUNT_W-1:0]  res_count_ff, res_count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_status_ff, rsp_status_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic [TOTAL_W-1:0]  rsp_total_ff, rsp_total_in;

   logic                ram_wr_en;
   logic [IDX_BITS-1:0] ram_wr_addr;
   logic [ENT_W-1:0]    ram_wr_data;
   logic [IDX_BITS-1:0] ram_rd_addr;
   logic [ENT_W-1:0]    ram_rd_data;

   logic [KEY_BITS-1:0] slot_key;
   logic [COUNT_W-1:0]  slot_cnt;
   logic [CNT_BITS-1:0] idx_nx;
   logic [CNT_BITS-1:0] idx_m1;
   logic [COUNT_W:0]    sum;
   logic [TOTAL_W-1:0]  total_add;

   assign slot_key  = ram_rd_data[ENT_W-1:COUNT_W];
   assign slot_cnt  = ram_rd_data[COUNT_W-1:0];
   assign idx_nx    = idx_ff + CNT_BITS'(1);
   assign idx_m1    = idx_ff - CNT_BITS'(1);
   assign sum       = {1'b0, cnt_ff} + {1'b0, add_ff};
   assign total_add = total_ff + TOTAL_W'(add_ff);

   assign ram_rd_addr = (state_ff == S_SHR) ? idx_m1[IDX_BITS-1:0] : idx_ff[IDX_BITS-1:0];

   sst_ram #(
      .WIDTH (ENT_W),
      .DEPTH (CAPACITY)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_item_count  = rsp_count_ff;
   assign rsp_total_units = rsp_total_ff;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      used_in       = used_ff;
      total_in      = total_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      add_in        = add_ff;
      hit_in        = hit_ff;
      cnt_in        = cnt_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_count_in  = res_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_total_in  = rsp_total_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = pos_ff[IDX_BITS-1:0];
      ram_wr_data   = {key_ff, add_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in = req_cmd;
               key_in = KEY_BITS'(req_item_key);
               add_in = req_add_count;
               hit_in = 1'b0;
               cnt_in = '0;
               pos_in = used_ff;
               idx_in = '0;
               state_in = (used_ff == '0) ? S_DECIDE : S_RD;
            end
         end
         S_RD: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            if (slot_key < key_ff) begin
               if (idx_nx == used_ff) begin
                  state_in = S_DECIDE;
               end else begin
                  idx_in   = idx_nx;
                  state_in = S_RD;
               end
            end else begin
               pos_in   = idx_ff;
               hit_in   = (slot_key == key_ff);
               cnt_in   = slot_cnt;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            res_status_in = STATUS_OK;
            res_found_in  = hit_ff;
            res_count_in  = hit_ff ? cnt_ff : '0;
            state_in      = S_DONE;
            if (cmd_ff == CMD_INSERT) begin
               if (hit_ff) begin
                  if (sum <= {1'b0, limit_ff}) begin
                     ram_wr_en    = 1'b1;
                     ram_wr_data  = {key_ff, sum[COUNT_W-1:0]};
                     total_in     = total_add;
                     res_count_in = sum[COUNT_W-1:0];
                  end else begin
                     res_status_in = STATUS_NOSPACE;
                  end
               end else if (used_ff < CNT_BITS'(CAPACITY) && add_ff <= limit_ff) begin
                  idx_in   = used_ff;
                  state_in = (used_ff == pos_ff) ? S_INS : S_SHR;
               end else begin
                  res_status_in = STATUS_NOSPACE;
               end
            end
         end
         S_SHR: begin
            state_in = S_SHW;
         end
         S_SHW: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_ff[IDX_BITS-1:0];
            ram_wr_data = ram_rd_data;
            idx_in      = idx_m1;
            state_in    = (idx_m1 == pos_ff) ? S_INS : S_SHR;
         end
         S_INS: begin
            ram_wr_en    = 1'b1;
            used_in      = used_ff + CNT_BITS'(1);
            total_in     = total_add;
            res_found_in = 1'b1;
            res_count_in = add_ff;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_found_in  = res_found_ff;
               rsp_count_in  = res_count_ff;
               rsp_total_in  = total_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         total_ff     <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      add_ff        <= add_in;
      hit_ff        <= hit_in;
      cnt_ff        <= cnt_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_count_ff  <= res_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_total_ff  <= rsp_total_in;
   end

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_BITS'(CAPACITY))
      else $error("slot count beyond capacity");

   a_used_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (used_ff == $past(used_ff)) || (used_ff == $past(used_ff) + CNT_BITS'(1)))
      else $error("slot count moved by more than one");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while busy");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == S_DECIDE || state_ff == S_SHW || state_ff == S_INS))
      else $error("slot write outside update states");

   a_absent_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_count_ff == '0))
      else $error("absent key with non-zero count");

endmodule

`default_nettype wire

/* tb/sorted_stack_count_table_tb.sv */
// testbench for the sorted stack count table: directed table then random requests,
// every response checked against the script's expected reply or a shadow copy of the sorted slots
// depends on sst_pkg and sorted_stack_count_table
`default_nettype none

module sorted_stack_count_table_tb
   import sst_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = CAPACITY_DEFAULT;
   localparam int PHASE_ITEMS = 205;

   typedef struct packed {
      logic                status;
      logic                found;
      logic [COUNT_W-1:0]  item_count;
      logic [TOTAL_W-1:0]  total_units;
   } reply_type;

   typedef struct packed {
      logic                   cmd;
      logic [KEY_PORT_W-1:0]  key;
      logic [COUNT_W-1:0]     add;
      logic                   typed;
      reply_type              want;
   } step_type;

   localparam reply_type UNTYPED = '0;

   // stack limit is at its reset value of 64 here
   localparam step_type SCRIPT [19] = '{
      '{CMD_QUERY,  16'h0000, 16'hFFFF, 1'b1, '{STATUS_OK,      1'b0, 16'd0,  20'd0}},
      '{CMD_INSERT, 16'd100,  16'd0,    1'b1, '{STATUS_OK,      1'b1, 16'd0,  20'd0}},
      '{CMD_INSERT, 16'd100,  16'd65,   1'b1, '{STATUS_NOSPACE, 1'b1, 16'd0,  20'd0}},
      '{CMD_INSERT, 16'd50,   16'd64,   1'b1, '{STATUS_OK,      1'b1, 16'd64, 20'd64}},
      '{CMD_INSERT, 16'd50,   16'd1,    1'b1, '{STATUS_NOSPACE, 1'b1, 16'd64, 20'd64}},
      '{CMD_INSERT, 16'hFFFF, 16'd10,   1'b1, '{STATUS_OK,      1'b1, 16'd10, 20'd74}},
      '{CMD_INSERT, 16'h0000, 16'd5,    1'b1, '{STATUS_OK,      1'b1, 16'd5,  20'd79}},
      '{CMD_QUERY,  16'd100,  16'h1234, 1'b1, '{STATUS_OK,      1'b1, 16'd0,  20'd79}},
      '{CMD_QUERY,  16'hFFFF, 16'h0000, 1'b1, '{STATUS_OK,      1'b1, 16'd10, 20'd79}},
      '{CMD_INSERT, 16'd100,  16'd64,   1'b1, '{STATUS_OK,      1'b1, 16'd64, 20'd143}},
      '{CMD_INSERT, 16'd200,  16'hFFFF, 1'b1, '{STATUS_NOSPACE, 1'b0, 16'd0,  20'd143}},
      '{CMD_QUERY,  16'd200,  16'h0000, 1'b1, '{STATUS_OK,      1'b0, 16'd0,  20'd143}},
      '{CMD_INSERT, 16'h5555, 16'hAAAA, 1'b1, '{STATUS_NOSPACE, 1'b0, 16'd0,  20'd143}},
      '{CMD_INSERT, 16'hAAAA, 16'd33,   1'b0, UNTYPED},
      '{CMD_INSERT, 16'h7FFF, 16'd7,    1'b0, UNTYPED},
      '{CMD_INSERT, 16'h8000, 16'd64,   1'b0, UNTYPED},
      '{CMD_QUERY,  16'h7FFF, 16'h0000, 1'b0, UNTYPED},
      '{CMD_INSERT, 16'h0001, 16'd0,    1'b0, UNTYPED},
      '{CMD_QUERY,  16'h0002, 16'h5A5A, 1'b0, UNTYPED}
   };

   localparam logic [COUNT_W-1:0] PHASE_LIMITS [8] = '{
      16'd0, 16'd1, 16'd100, 16'd40, 16'd1000, 16'd0, 16'd65534, 16'd65535
   };
   localparam int RANDOM_LIMIT_PHASE = 5;
   localparam int STEADY_PHASE = 4;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_cmd = CMD_INSERT;
   logic [KEY_PORT_W-1:0]  req_item_key = '0;
   logic [COUNT_W-1:0]     req_add_count = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_status;
   logic                   rsp_found;
   logic [COUNT_W-1:0]     rsp_item_count;
   logic [TOTAL_W-1:0]     rsp_total_units;
   logic                   csr_wr_en = 1'b0;
   logic [COUNT_W-1:0]     csr_wr_data = '0;

   logic [KEY_PORT_W-1:0]  shadow_keys [SLOTS];
   logic [COUNT_W-1:0]     shadow_counts [SLOTS];
   int unsigned            shadow_used = 0;
   logic [TOTAL_W-1:0]     shadow_total = '0;
   logic [COUNT_W-1:0]     shadow_limit = LIMIT_RESET;

   reply_type owed_replies [$];
   int        mismatches = 0;
   bit        steady = 1'b0;

   sorted_stack_count_table DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_item_key    (req_item_key),
      .req_add_count   (req_add_count),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_found       (rsp_found),
      .rsp_item_count  (rsp_item_count),
      .rsp_total_units (rsp_total_units),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #1500000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic int unsigned lower_slot(input logic [KEY_PORT_W-1:0] key);
      int unsigned i;
      i = 0;
      while (i < shadow_used && shadow_keys[i] < key) i++;
      return i;
   endfunction

   function automatic bit slot_has(input int unsigned pos, input logic [KEY_PORT_W-1:0] key);
      return pos < shadow_used && shadow_keys[pos] == key;
   endfunction

   function automatic logic [COUNT_W-1:0] held_count(input logic [KEY_PORT_W-1:0] key);
      int unsigned pos;
      pos = lower_slot(key);
      return slot_has(pos, key) ? shadow_counts[pos] : '0;
   endfunction

   task automatic apply_table_op(input logic cmd, input logic [KEY_PORT_W-1:0] key,
                                 input logic [COUNT_W-1:0] add, output reply_type r);
      int unsigned pos;
      logic [COUNT_W:0] sum;
      bit hit;
      pos = lower_slot(key);
      r.status = STATUS_OK;
      if (cmd == CMD_INSERT) begin
         if (slot_has(pos, key)) begin
            sum = {1'b0, shadow_counts[pos]} + {1'b0, add};
            if (sum <= {1'b0, shadow_limit}) begin
               shadow_counts[pos] = sum[COUNT_W-1:0];
               shadow_total = shadow_total + TOTAL_W'(add);
            end else begin
               r.status = STATUS_NOSPACE;
            end
         end else if (shadow_used < SLOTS && add <= shadow_limit) begin
            for (int i = shadow_used; i > pos; i--) begin
               shadow_keys[i] = shadow_keys[i-1];
               shadow_counts[i] = shadow_counts[i-1];
            end
            shadow_keys[pos] = key;
            shadow_counts[pos] = add;
            shadow_used++;
            shadow_total = shadow_total + TOTAL_W'(add);
         end else begin
            r.status = STATUS_NOSPACE;
         end
      end
      hit = slot_has(pos, key);
      r.found = hit;
      r.item_count = hit ? shadow_counts[pos] : '0;
      r.total_units = shadow_total;
   endtask

   function automatic logic [KEY_PORT_W-1:0] pick_key();
      int unsigned r;
      logic [KEY_PORT_W-1:0] base;
      r = $urandom_range(99);
      if (shadow_used == 0 || r < 3) begin
         base = KEY_PORT_W'($urandom_range(65535));
      end else begin
         base = shadow_keys[$urandom_range(shadow_used - 1)];
         if (r < 6) base = $urandom_range(1) ? base + 1'b1 : base - 1'b1;
      end
      return base;
   endfunction

   function automatic logic [COUNT_W-1:0] pick_add(input logic [KEY_PORT_W-1:0] key);
      int unsigned r;
      logic [COUNT_W-1:0] held;
      logic [COUNT_W:0] room;
      r = $urandom_range(99);
      held = held_count(key);
      room = (shadow_limit >= held) ? {1'b0, shadow_limit} - {1'b0, held} : '0;
      if (r < 30) return COUNT_W'($urandom_range(3));
      if (r < 50) return room[COUNT_W-1:0];
      if (r < 60) return (room >= 17'd65535) ? 16'hFFFF : COUNT_W'(room + 1'b1);
      if (r < 80) return COUNT_W'($urandom_range(shadow_limit));
      return COUNT_W'($urandom_range(65535));
   endfunction

   task automatic offer(input logic cmd, input logic [KEY_PORT_W-1:0] key,
                        input logic [COUNT_W-1:0] add, input logic typed,
                        input reply_type typed_want);
      reply_type want;
      while (!steady && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_item_key <= key;
      req_add_count <= add;
      do @(posedge clock); while (!req_ready);
      apply_table_op(cmd, key, add, want);
      owed_replies.push_back(typed ? typed_want : want);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (owed_replies.size() != 0) @(posedge clock);
   endtask

   task automatic set_limit(input logic [COUNT_W-1:0] value);
      drain();
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      shadow_limit = value;
   endtask

   always @(posedge clock) begin : rsp_side
      reply_type got;
      reply_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || ($urandom_range(99) >= 28);
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_status, rsp_found, rsp_item_count, rsp_total_units};
            if (owed_replies.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"response with no request outstanding: ",
                            "status %0d found %0d count %0d total %0d"},
                           got.status, got.found, got.item_count, got.total_units);
            end else begin
               want = owed_replies.pop_front();
               if (got.status !== want.status || got.found !== want.found ||
                   got.item_count !== want.item_count || got.total_units !== want.total_units) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch (exp/got): status %0d/%0d found %0d/%0d ",
                               "count %0d/%0d total %0d/%0d"},
                              want.status, got.status, want.found, got.found,
                              want.item_count, got.item_count, want.total_units, got.total_units);
               end
            end
         end
      end
   end

   initial begin : stimulus
      logic cmd;
      logic [KEY_PORT_W-1:0] key;
      logic [COUNT_W-1:0] add;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      foreach (SCRIPT[i])
         offer(SCRIPT[i].cmd, SCRIPT[i].key, SCRIPT[i].add, SCRIPT[i].typed, SCRIPT[i].want);
      for (int p = 0; p < 8; p++) begin
         set_limit(p == RANDOM_LIMIT_PHASE ? COUNT_W'($urandom_range(65535)) : PHASE_LIMITS[p]);
         steady = (p == STEADY_PHASE);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            cmd = ($urandom_range(99) < 40) ? CMD_QUERY : CMD_INSERT;
            key = pick_key();
            add = (cmd == CMD_QUERY) ? COUNT_W'($urandom_range(65535)) : pick_add(key);
            offer(cmd, key, add, 1'b0, UNTYPED);
         end
      end
      steady = 1'b0;
      drain();
      repeat (100) @(posedge clock);
      if (mismatches == 0 && owed_replies.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

`default_nettype wire

/* sim.f */
src/sst_pkg.sv
src/sst_ram.sv
src/sorted_stack_count_table.sv
tb/sorted_stack_count_table_tb.sv
